/* rtl/core/bmm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_pkg
// shared types, constants and helpers of the batched matrix multiply core
// ----------------------------------------------------------------------------
package bmm_pkg;

    // fixed widths of the fields
    localparam int DATA_W        = 32;
    localparam int DIM_W         = 4;
    localparam int IDX_W         = 6;
    localparam int POS_W         = 3;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int STORE_DEPTH   = 64;

    // arithmetic setup
    localparam int MAX_DIM       = 8;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * DATA_W;
    // room for the sum of up to eight full products
    localparam int ACC_W         = PROD_W + 3;
    localparam int RND_W         = ACC_W + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_MULTIPLY   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_RIGHT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // control that travels with one multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

    // zero reads as one, above the maximum reads as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0) begin
                res = DIM_W'(1);
            end else if (v > DIM_W'(MAX_DIM)) begin
                res = DIM_W'(MAX_DIM);
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/batched_matrix_multiply_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// batched_matrix_multiply_core
// fixed-point matrix multiply engine with left and right element stores
// ----------------------------------------------------------------------------
// usage:
//   configuration channel sets rows_left, inner_size and cols_right (index
//   0..2, other indexes ignored); write only while the core is idle
//   input beats: operation 0/1 writes one q16.16 element to the left/right
//   store at element_index, one beat per cycle while idle, no result beat
//   operation 2 walks every product element in row-major order, one
//   multiply-accumulate per cycle through the store read ports unless the
//   output stalls; no input beat is taken while the walk runs
//   each result passes the store read, product, accumulate, rounding and
//   result registers in turn; o_last marks the final element
//   each result is the exact sum, rounded to nearest (ties up) and saturated
//   a stalled output freezes the whole pipeline; nothing is dropped
//   reset clears control only; stores hold nothing valid until loaded
// ----------------------------------------------------------------------------
module batched_matrix_multiply_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [bmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [bmm_pkg::DIM_W-1:0]      i_cfg_data,
    // input beats
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic        [bmm_pkg::OP_W-1:0]       i_operation,
    input  wire logic        [bmm_pkg::IDX_W-1:0]      i_element_index,
    input  wire logic signed [bmm_pkg::DATA_W-1:0]     i_element_value,
    // result beats
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed      [bmm_pkg::DATA_W-1:0]     o_product_value,
    output logic             [bmm_pkg::POS_W-1:0]      o_product_row,
    output logic             [bmm_pkg::POS_W-1:0]      o_product_col,
    output logic                                       o_last
);
    import bmm_pkg::*;

    // dimension registers
    logic [DIM_W-1:0] r_rows_left, r_inner_size, r_cols_right;
    logic [DIM_W-1:0] w_rows, w_inner, w_cols;

    logic w_cfg_we;
    logic w_in_acc;
    logic w_idle;
    logic w_adv;
    logic [IDX_W-1:0]  w_left_addr, w_right_addr;
    logic [DATA_W-1:0] w_left_data, w_right_data;
    t_tag              w_tag;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_left  <= DIM_W'(1);
            r_inner_size <= DIM_W'(1);
            r_cols_right <= DIM_W'(1);
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS_LEFT:  r_rows_left  <= i_cfg_data;
                REG_INNER_SIZE: r_inner_size <= i_cfg_data;
                REG_COLS_RIGHT: r_cols_right <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // out-of-range dimensions are pulled into 1..max
    assign w_rows  = clamp_dim(r_rows_left);
    assign w_inner = clamp_dim(r_inner_size);
    assign w_cols  = clamp_dim(r_cols_right);

    // input beats are taken only between multiply commands
    assign o_in_ready = w_idle;
    assign w_in_acc   = i_in_valid && o_in_ready;

    bmm_store u_left_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && (i_operation == OP_LOAD_LEFT)),
        .i_wr_addr (i_element_index),
        .i_wr_data (i_element_value),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_left_addr),
        .o_rd_data (w_left_data)
    );

    bmm_store u_right_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && (i_operation == OP_LOAD_RIGHT)),
        .i_wr_addr (i_element_index),
        .i_wr_data (i_element_value),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_right_addr),
        .o_rd_data (w_right_data)
    );

    bmm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_in_acc && (i_operation == OP_MULTIPLY)),
        .i_adv        (w_adv),
        .i_rows       (w_rows),
        .i_inner      (w_inner),
        .i_cols       (w_cols),
        .o_idle       (w_idle),
        .o_left_addr  (w_left_addr),
        .o_right_addr (w_right_addr),
        .o_tag        (w_tag)
    );

    bmm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tag           (w_tag),
        .i_left          ($signed(w_left_data)),
        .i_right         ($signed(w_right_data)),
        .o_adv           (w_adv),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product_value (o_product_value),
        .o_product_row   (o_product_row),
        .o_product_col   (o_product_col),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

/* rtl/core/bmm_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_store
// element store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bmm_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [bmm_pkg::IDX_W-1:0]  i_wr_addr,
    input  wire logic [bmm_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [bmm_pkg::IDX_W-1:0]  i_rd_addr,
    output logic      [bmm_pkg::DATA_W-1:0] o_rd_data
);
    import bmm_pkg::*;

    logic [DATA_W-1:0] r_mem [STORE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* rtl/core/bmm_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_seq
// walks rows, columns and inner index, issuing store reads one step a cycle unless i_adv holds it
// ----------------------------------------------------------------------------
module bmm_seq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_adv,
    input  wire logic [bmm_pkg::DIM_W-1:0] i_rows,
    input  wire logic [bmm_pkg::DIM_W-1:0] i_inner,
    input  wire logic [bmm_pkg::DIM_W-1:0] i_cols,
    output logic                           o_idle,
    output logic [bmm_pkg::IDX_W-1:0]      o_left_addr,
    output logic [bmm_pkg::IDX_W-1:0]      o_right_addr,
    output bmm_pkg::t_tag                  o_tag
);
    import bmm_pkg::*;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_lbase, n_lbase;
    logic [IDX_W-1:0] r_laddr, n_laddr;
    logic [IDX_W-1:0] r_raddr, n_raddr;

    logic w_lastk, w_lastc, w_lastr;
    logic [IDX_W-1:0] w_lbase_next;

    assign w_lastk = ({1'b0, r_k}   == (i_inner - DIM_W'(1)));
    assign w_lastc = ({1'b0, r_col} == (i_cols  - DIM_W'(1)));
    assign w_lastr = ({1'b0, r_row} == (i_rows  - DIM_W'(1)));
    assign w_lbase_next = r_lbase + IDX_W'(i_inner);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_k     <= n_k;
        r_lbase <= n_lbase;
        r_laddr <= n_laddr;
        r_raddr <= n_raddr;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        n_lbase = r_lbase;
        n_laddr = r_laddr;
        n_raddr = r_raddr;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                    n_lbase = '0;
                    n_laddr = '0;
                    n_raddr = '0;
                end
            end
            ST_RUN: begin
                if (i_adv) begin
                    if (!w_lastk) begin
                        // next inner step: left moves along the row, right down the column
                        n_k     = r_k + POS_W'(1);
                        n_laddr = r_laddr + IDX_W'(1);
                        n_raddr = r_raddr + IDX_W'(i_cols);
                    end else if (!w_lastc) begin
                        n_k     = '0;
                        n_col   = r_col + POS_W'(1);
                        n_laddr = r_lbase;
                        n_raddr = IDX_W'(r_col) + IDX_W'(1);
                    end else if (!w_lastr) begin
                        n_k     = '0;
                        n_col   = '0;
                        n_row   = r_row + POS_W'(1);
                        n_lbase = w_lbase_next;
                        n_laddr = w_lbase_next;
                        n_raddr = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_left_addr  = r_laddr;
    assign o_right_addr = r_raddr;

    always_comb begin
        o_tag.valid = (r_state == ST_RUN);
        o_tag.first = (r_k == '0);
        o_tag.lastk = w_lastk;
        o_tag.last  = w_lastk && w_lastc && w_lastr;
        o_tag.row   = r_row;
        o_tag.col   = r_col;
    end

endmodule
`default_nettype wire

/* rtl/core/bmm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_datapath
// multiply, exact accumulate, round and saturate, result register
// ----------------------------------------------------------------------------
module bmm_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bmm_pkg::t_tag                     i_tag,
    input  wire logic signed [bmm_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [bmm_pkg::DATA_W-1:0] i_right,
    output logic                                   o_adv,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [bmm_pkg::DATA_W-1:0]      o_product_value,
    output logic        [bmm_pkg::POS_W-1:0]       o_product_row,
    output logic        [bmm_pkg::POS_W-1:0]       o_product_col,
    output logic                                   o_last
);
    import bmm_pkg::*;

    localparam logic [RND_W-1:0] HALF = (RND_W'(1) << FRACTION_BITS) >> 1;

    t_tag r_s1, r_s2, r_s3, r_s4;
    t_tag n_s4;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [RND_W-1:0]  r_rnd;
    logic signed [RND_W-1:0]  w_shift;
    logic signed [DATA_W-1:0] w_sat;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_value;
    logic [POS_W-1:0]         r_row, r_col;
    logic                     r_last;

    // whole pipe holds while a finished result waits
    assign o_adv = !r_out_valid || i_out_ready;

    // only the final inner step of an element goes on to rounding
    always_comb begin
        n_s4       = r_s3;
        n_s4.valid = r_s3.valid && r_s3.lastk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_s4        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s1 <= i_tag;
                r_s2 <= r_s1;
                r_s3 <= r_s2;
                r_s4 <= n_s4;
            end
            if (o_adv) begin
                r_out_valid <= r_s4.valid;
            end
        end
    end

    always_comb begin
        if (r_s2.first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    assign w_shift = r_rnd >>> FRACTION_BITS;

    always_comb begin
        if (&w_shift[RND_W-1:DATA_W-1] || ~|w_shift[RND_W-1:DATA_W-1]) begin
            w_sat = w_shift[DATA_W-1:0];
        end else if (w_shift[RND_W-1]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_prod <= i_left * i_right;
            if (r_s2.valid) begin
                r_acc <= n_acc;
            end
            r_rnd <= RND_W'(r_acc) + $signed(HALF);
            if (r_s4.valid) begin
                r_value <= w_sat;
                r_row   <= r_s4.row;
                r_col   <= r_s4.col;
                r_last  <= r_s4.last;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_product_value = r_value;
    assign o_product_row   = r_row;
    assign o_product_col   = r_col;
    assign o_last          = r_last;

endmodule
`default_nettype wire
